@@ rtl/pidmsc_pkg.sv @@
// ----------------------------------------------------------------------------
// pidmsc_pkg: shared types and constants of the PID motor speed control unit
// Field widths, register indexes, drive mode codes, reset values, the
// sequencer state type and the divider status bundle.
// ----------------------------------------------------------------------------
package pidmsc_pkg;

    // Fixed field widths
    localparam int MAG_W     = 32;  // signed Q8.24 words and their magnitudes
    localparam int IVL_W     = 31;  // interval, unsigned
    localparam int PERIOD_W  = 16;  // PWM period and compare value
    localparam int MODE_W    = 2;   // drive mode
    localparam int START_W   = 25;  // start power and drive power
    localparam int CFG_IDX_W = 3;   // configuration register index

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MODE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_START_POWER = 3'd6;

    // Drive mode codes
    localparam logic [MODE_W-1:0] MODE_FORWARD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REVERSE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BRAKE   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_COAST   = 2'd3;

    // Register reset values
    localparam logic [MAG_W-1:0]    RST_SETPOINT   = 32'd0;
    localparam logic [MAG_W-1:0]    RST_GAIN_P     = 32'd2516582;
    localparam logic [MAG_W-1:0]    RST_GAIN_I     = 32'd2516582;
    localparam logic [MAG_W-1:0]    RST_GAIN_D     = 32'd839;
    localparam logic [PERIOD_W-1:0] RST_PWM_PERIOD = 16'd7999;
    localparam logic [MODE_W-1:0]   RST_DRIVE_MODE = MODE_COAST;

    // Signed 32-bit limits
    localparam logic [MAG_W-1:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [MAG_W-1:0] S32_MIN = 32'h8000_0000;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOAD,
        ST_INC_RUN,
        ST_INC_POST,
        ST_INTEG,
        ST_P_RUN,
        ST_P_POST,
        ST_I_START,
        ST_I_RUN,
        ST_I_POST,
        ST_D_START,
        ST_D_RUN,
        ST_D_POST,
        ST_SUM,
        ST_PWR,
        ST_PWM_START,
        ST_PWM_RUN
    } state_t;

    // Divider status toward the sequencer
    typedef struct packed {
        logic             busy;
        logic             neg;  // sign of the quotient
        logic [MAG_W-1:0] mag;  // saturated quotient magnitude
    } div_status_t;

endpackage

@@ rtl/pidmsc_serial_mul.sv @@
// ----------------------------------------------------------------------------
// pidmsc_serial_mul: bit-serial unsigned multiplier
// Shift-add multiplier that retires one multiplier bit per clock; the product
// is A_W + B_W bits and stays stable once busy falls.
// ----------------------------------------------------------------------------
module pidmsc_serial_mul #(
    parameter int A_W = 48,
    parameter int B_W = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [A_W-1:0]       a,
    input  logic [B_W-1:0]       b,
    output logic                 busy,
    output logic [A_W+B_W-1:0]   product
);

    localparam int CNT_W = $clog2(B_W + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [A_W-1:0]   a_reg;
    logic [B_W-1:0]   b_reg;
    logic [A_W+B_W-1:0] acc_reg;

    logic [A_W-1:0]   addend;
    logic [A_W:0]     part_sum;

    // One partial product per cycle, added into the upper A_W bits of the accumulator
    always_comb
    begin
        addend   = b_reg[0] ? a_reg : '0;
        part_sum = {1'b0, acc_reg[A_W+B_W-1:B_W]} + {1'b0, addend};
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(B_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Operand and accumulator shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            b_reg   <= {1'b0, b_reg[B_W-1:1]};
            acc_reg <= {part_sum, acc_reg[B_W-1:1]};
        end
    end

    assign busy    = busy_reg;
    assign product = acc_reg;

endmodule

@@ rtl/pidmsc_serial_div.sv @@
// ----------------------------------------------------------------------------
// pidmsc_serial_div: bit-serial restoring divider for the derivative term
// Produces one quotient bit per clock, truncating toward zero, and reports the
// quotient as a sign and a magnitude saturated to the signed 32-bit range.
// A zero divisor gives a zero quotient.
// ----------------------------------------------------------------------------
module pidmsc_serial_div #(
    parameter int NUM_W = 57
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [NUM_W-1:0]              num_mag,
    input  logic                          num_neg,
    input  logic [pidmsc_pkg::IVL_W-1:0]  den,
    output pidmsc_pkg::div_status_t       status
);

    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam int D_W   = pidmsc_pkg::IVL_W;
    localparam int M_W   = pidmsc_pkg::MAG_W;

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [D_W-1:0]   rem_reg;
    logic [D_W-1:0]   den_reg;
    logic             neg_reg;
    logic             zero_reg;

    logic [D_W:0]     trial;
    logic [D_W:0]     trial_diff;
    logic             fits;
    logic [M_W-1:0]   limit;
    logic             too_big;

    // Trial subtraction for the next quotient bit
    always_comb
    begin
        trial      = {rem_reg, quo_reg[NUM_W-1]};
        trial_diff = trial - {1'b0, den_reg};
        fits       = (trial >= {1'b0, den_reg});
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Dividend shifts out at the top while quotient bits shift in at the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg  <= num_mag;
            rem_reg  <= '0;
            den_reg  <= den;
            neg_reg  <= num_neg;
            zero_reg <= (den == '0);
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? trial_diff[D_W-1:0] : trial[D_W-1:0];
        end
    end

    // Saturate the magnitude: 2^31 for a negative quotient, 2^31-1 otherwise
    always_comb
    begin
        limit   = neg_reg ? pidmsc_pkg::S32_MIN : pidmsc_pkg::S32_MAX;
        too_big = (|quo_reg[NUM_W-1:M_W]) || (quo_reg[M_W-1:0] > limit);
        status.busy = busy_reg;
        status.neg  = neg_reg;
        if (zero_reg)
        begin
            status.mag = '0;
        end
        else if (too_big)
        begin
            status.mag = limit;
        end
        else
        begin
            status.mag = quo_reg[M_W-1:0];
        end
    end

endmodule

@@ rtl/pid_motor_speed_control_unit.sv @@
// ----------------------------------------------------------------------------
// pid_motor_speed_control_unit: speed PID loop for one H-bridge motor channel
// Takes a speed sample and its interval, updates the saturating integral and
// the drive power, and returns the PWM compare value and bridge levels.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload
//  -------   ------------------   ------------------------------------------
//  cfg       cfg_we               cfg_index, cfg_data (write only)
//  in        in_valid / in_stall  measured_speed, interval
//  out       out_valid/out_stall  pwm_compare, bridge_in_one, bridge_in_two,
//                                 drive_power, correction
//
//  Between input transfer and output valid an item makes five passes through
//  the shared bit-serial multiplier, plus sequencing. The bit-serial divider
//  runs alongside the first two.
//  in_stall is high while an item is in work; a result waiting in the output
//  register does not block the next input, only the next result.
//  Reset (rst_n, async) restores register defaults and zeroes the loop state.
//
module pid_motor_speed_control_unit #(
    parameter int FRAC_BITS      = 24,
    parameter int INTEGRAL_WIDTH = 48
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration
    input  logic                                  cfg_we,
    input  logic [pidmsc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pidmsc_pkg::MAG_W-1:0]          cfg_data,
    // samples in
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [pidmsc_pkg::MAG_W-1:0]   measured_speed,
    input  logic [pidmsc_pkg::IVL_W-1:0]          interval,
    // results out
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [pidmsc_pkg::PERIOD_W-1:0]       pwm_compare,
    output logic                                  bridge_in_one,
    output logic                                  bridge_in_two,
    output logic [pidmsc_pkg::START_W-1:0]        drive_power,
    output logic signed [pidmsc_pkg::MAG_W-1:0]   correction
);

    localparam int M_W    = pidmsc_pkg::MAG_W;
    localparam int IW     = INTEGRAL_WIDTH;
    localparam int PWR_W  = (FRAC_BITS + 1 > pidmsc_pkg::START_W) ?
                            FRAC_BITS + 1 : pidmsc_pkg::START_W;
    localparam int PROD_W = IW + M_W;
    localparam int QW     = PROD_W - FRAC_BITS;
    localparam int EXT_W  = QW + 2;
    localparam int SUM_W  = ((EXT_W > IW) ? EXT_W : IW) + 1;
    localparam int DIV_W  = M_W + 1 + FRAC_BITS;
    localparam int PSUM_W = ((PWR_W > M_W) ? PWR_W : M_W) + 2;
    localparam int CSUM_W = M_W + 2;

    localparam logic [PWR_W-1:0] ONE_Q     = {{(PWR_W-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic [IW-1:0]    INTEG_MAX = {1'b0, {(IW-1){1'b1}}};
    localparam logic [IW-1:0]    INTEG_MIN = {1'b1, {(IW-1){1'b0}}};

    // Two's complement magnitude of a 32-bit word
    function automatic logic [M_W-1:0] abs32(input logic [M_W-1:0] v);
        abs32 = v[M_W-1] ? (~v + M_W'(1)) : v;
    endfunction

    // Sequencer
    pidmsc_pkg::state_t state_reg, state_next;

    // Configuration registers
    logic [M_W-1:0]                      setpoint_reg;
    logic [M_W-1:0]                      gain_p_reg;
    logic [M_W-1:0]                      gain_i_reg;
    logic [M_W-1:0]                      gain_d_reg;
    logic [pidmsc_pkg::PERIOD_W-1:0]     period_reg;
    logic [pidmsc_pkg::MODE_W-1:0]       mode_reg;

    // Loop state
    logic [IW-1:0]    integral_reg;
    logic [M_W-1:0]   last_error_reg;
    logic [PWR_W-1:0] power_reg;

    // Per-item working registers
    logic [M_W-1:0]                  err_reg;
    logic [pidmsc_pkg::IVL_W-1:0]    ivl_reg;
    logic                            op_neg_reg;
    logic [EXT_W-1:0]                sv_reg;
    logic [M_W-1:0]                  term_p_reg;
    logic [M_W-1:0]                  term_i_reg;
    logic [M_W-1:0]                  corr_reg;

    // Output register
    logic                            out_valid_reg;
    logic [pidmsc_pkg::PERIOD_W-1:0] pwm_compare_reg;
    logic                            bridge_one_reg;
    logic                            bridge_two_reg;
    logic [pidmsc_pkg::START_W-1:0]  drive_power_reg;
    logic [M_W-1:0]                  correction_reg;

    // Handshake and control
    logic in_accept;
    logic out_room;
    logic mul_start;
    logic [IW-1:0]   mul_a;
    logic [M_W-1:0]  mul_b;
    logic mul_neg;
    logic mul_busy;
    logic [PROD_W-1:0] mul_product;
    logic div_start;
    logic post_load;
    logic out_load;
    pidmsc_pkg::div_status_t div_status;

    // Datapath intermediates
    logic [M_W:0]      err_sub;
    logic [M_W-1:0]    err_in;
    logic [M_W:0]      diff;
    logic [M_W:0]      diff_mag;
    logic [DIV_W-1:0]  div_num;
    logic [M_W-1:0]    err_mag;
    logic [IW-1:0]     integ_mag;
    logic [QW-1:0]     q_w;
    logic              rem_w;
    logic [EXT_W-1:0]  sv_w;
    logic [EXT_W-M_W:0] sv_top;
    logic [M_W-1:0]    sv_sat;
    logic [SUM_W-1:0]  isum;
    logic [SUM_W-IW:0] isum_top;
    logic [IW-1:0]     integ_next;
    logic [CSUM_W-1:0] csum;
    logic [M_W-1:0]    corr_next;
    logic [PSUM_W-1:0] psum;
    logic [PWR_W-1:0]  power_next;
    logic [PWR_W-1:0]  start_clamped;

    assign in_stall  = (state_reg != pidmsc_pkg::ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_room  = !out_valid_reg || !out_stall;

    // Saturated error from the incoming sample
    always_comb
    begin
        err_sub = {setpoint_reg[M_W-1], setpoint_reg} - {measured_speed[M_W-1], measured_speed};
        if (err_sub[M_W] != err_sub[M_W-1])
        begin
            err_in = err_sub[M_W] ? pidmsc_pkg::S32_MIN : pidmsc_pkg::S32_MAX;
        end
        else
        begin
            err_in = err_sub[M_W-1:0];
        end
    end

    // Derivative dividend: |error - last error| scaled by one
    always_comb
    begin
        diff     = {err_reg[M_W-1], err_reg} - {last_error_reg[M_W-1], last_error_reg};
        diff_mag = diff[M_W] ? (~diff + (M_W+1)'(1)) : diff;
        div_num  = {diff_mag, {FRAC_BITS{1'b0}}};
        err_mag  = abs32(err_reg);
        integ_mag = integral_reg[IW-1] ? (~integral_reg + IW'(1)) : integral_reg;
    end

    // Product post-processing: floor by 2^FRAC_BITS with the product sign
    always_comb
    begin
        q_w   = mul_product[PROD_W-1:FRAC_BITS];
        rem_w = |mul_product[FRAC_BITS-1:0];
        sv_w  = op_neg_reg ? (~{2'b00, q_w} + EXT_W'(!rem_w)) : {2'b00, q_w};
        sv_top = sv_reg[EXT_W-1:M_W-1];
        if ((&sv_top) || !(|sv_top))
        begin
            sv_sat = sv_reg[M_W-1:0];
        end
        else
        begin
            sv_sat = sv_reg[EXT_W-1] ? pidmsc_pkg::S32_MIN : pidmsc_pkg::S32_MAX;
        end
    end

    // Saturating integral update
    always_comb
    begin
        isum = {{(SUM_W-IW){integral_reg[IW-1]}}, integral_reg}
             + {{(SUM_W-EXT_W){sv_reg[EXT_W-1]}}, sv_reg};
        isum_top = isum[SUM_W-1:IW-1];
        if ((&isum_top) || !(|isum_top))
        begin
            integ_next = isum[IW-1:0];
        end
        else
        begin
            integ_next = isum[SUM_W-1] ? INTEG_MIN : INTEG_MAX;
        end
    end

    // Correction sum and clamped power
    always_comb
    begin
        csum = {{2{term_p_reg[M_W-1]}}, term_p_reg}
             + {{2{term_i_reg[M_W-1]}}, term_i_reg}
             + {{2{sv_sat[M_W-1]}}, sv_sat};
        if (csum[CSUM_W-1:M_W-1] == '0 || (&csum[CSUM_W-1:M_W-1]))
        begin
            corr_next = csum[M_W-1:0];
        end
        else
        begin
            corr_next = csum[CSUM_W-1] ? pidmsc_pkg::S32_MIN : pidmsc_pkg::S32_MAX;
        end

        psum = {{(PSUM_W-PWR_W){1'b0}}, power_reg}
             + {{(PSUM_W-M_W){corr_reg[M_W-1]}}, corr_reg};
        if (psum[PSUM_W-1])
        begin
            power_next = '0;
        end
        else if (psum > PSUM_W'(ONE_Q))
        begin
            power_next = ONE_Q;
        end
        else
        begin
            power_next = psum[PWR_W-1:0];
        end

        start_clamped = (PWR_W'(cfg_data[pidmsc_pkg::START_W-1:0]) > ONE_Q) ?
                        ONE_Q : PWR_W'(cfg_data[pidmsc_pkg::START_W-1:0]);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pidmsc_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = pidmsc_pkg::ST_LOAD;
                end
            end
            pidmsc_pkg::ST_LOAD:      state_next = pidmsc_pkg::ST_INC_RUN;
            pidmsc_pkg::ST_INC_RUN:
            begin
                if (!mul_busy)
                begin
                    state_next = pidmsc_pkg::ST_INC_POST;
                end
            end
            pidmsc_pkg::ST_INC_POST:  state_next = pidmsc_pkg::ST_INTEG;
            pidmsc_pkg::ST_INTEG:     state_next = pidmsc_pkg::ST_P_RUN;
            pidmsc_pkg::ST_P_RUN:
            begin
                if (!mul_busy)
                begin
                    state_next = pidmsc_pkg::ST_P_POST;
                end
            end
            pidmsc_pkg::ST_P_POST:    state_next = pidmsc_pkg::ST_I_START;
            pidmsc_pkg::ST_I_START:   state_next = pidmsc_pkg::ST_I_RUN;
            pidmsc_pkg::ST_I_RUN:
            begin
                if (!mul_busy)
                begin
                    state_next = pidmsc_pkg::ST_I_POST;
                end
            end
            pidmsc_pkg::ST_I_POST:    state_next = pidmsc_pkg::ST_D_START;
            pidmsc_pkg::ST_D_START:
            begin
                if (!div_status.busy)
                begin
                    state_next = pidmsc_pkg::ST_D_RUN;
                end
            end
            pidmsc_pkg::ST_D_RUN:
            begin
                if (!mul_busy)
                begin
                    state_next = pidmsc_pkg::ST_D_POST;
                end
            end
            pidmsc_pkg::ST_D_POST:    state_next = pidmsc_pkg::ST_SUM;
            pidmsc_pkg::ST_SUM:       state_next = pidmsc_pkg::ST_PWR;
            pidmsc_pkg::ST_PWR:       state_next = pidmsc_pkg::ST_PWM_START;
            pidmsc_pkg::ST_PWM_START: state_next = pidmsc_pkg::ST_PWM_RUN;
            pidmsc_pkg::ST_PWM_RUN:
            begin
                if (!mul_busy && out_room)
                begin
                    state_next = pidmsc_pkg::ST_IDLE;
                end
            end
            default:                  state_next = pidmsc_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: multiplier operands and load strobes
    always_comb
    begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        mul_neg   = 1'b0;
        div_start = 1'b0;
        post_load = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            pidmsc_pkg::ST_LOAD:
            begin
                // error * interval, divider started alongside
                mul_start = 1'b1;
                mul_a     = IW'(err_mag);
                mul_b     = M_W'(ivl_reg);
                mul_neg   = err_reg[M_W-1];
                div_start = 1'b1;
            end
            pidmsc_pkg::ST_INTEG:
            begin
                mul_start = 1'b1;
                mul_a     = IW'(err_mag);
                mul_b     = abs32(gain_p_reg);
                mul_neg   = err_reg[M_W-1] ^ gain_p_reg[M_W-1];
            end
            pidmsc_pkg::ST_I_START:
            begin
                mul_start = 1'b1;
                mul_a     = integ_mag;
                mul_b     = abs32(gain_i_reg);
                mul_neg   = integral_reg[IW-1] ^ gain_i_reg[M_W-1];
            end
            pidmsc_pkg::ST_D_START:
            begin
                mul_start = !div_status.busy;
                mul_a     = IW'(div_status.mag);
                mul_b     = abs32(gain_d_reg);
                mul_neg   = div_status.neg ^ gain_d_reg[M_W-1];
            end
            pidmsc_pkg::ST_PWM_START:
            begin
                mul_start = 1'b1;
                mul_a     = IW'(power_reg);
                mul_b     = M_W'(period_reg);
            end
            pidmsc_pkg::ST_INC_POST,
            pidmsc_pkg::ST_P_POST,
            pidmsc_pkg::ST_I_POST,
            pidmsc_pkg::ST_D_POST:
            begin
                post_load = 1'b1;
            end
            pidmsc_pkg::ST_PWM_RUN:
            begin
                out_load = !mul_busy && out_room;
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    // Control state, configuration and loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pidmsc_pkg::ST_IDLE;
            setpoint_reg   <= pidmsc_pkg::RST_SETPOINT;
            gain_p_reg     <= pidmsc_pkg::RST_GAIN_P;
            gain_i_reg     <= pidmsc_pkg::RST_GAIN_I;
            gain_d_reg     <= pidmsc_pkg::RST_GAIN_D;
            period_reg     <= pidmsc_pkg::RST_PWM_PERIOD;
            mode_reg       <= pidmsc_pkg::RST_DRIVE_MODE;
            power_reg      <= '0;
            integral_reg   <= '0;
            last_error_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    pidmsc_pkg::REG_SETPOINT:    setpoint_reg <= cfg_data;
                    pidmsc_pkg::REG_GAIN_P:      gain_p_reg   <= cfg_data;
                    pidmsc_pkg::REG_GAIN_I:      gain_i_reg   <= cfg_data;
                    pidmsc_pkg::REG_GAIN_D:      gain_d_reg   <= cfg_data;
                    pidmsc_pkg::REG_PWM_PERIOD:
                        period_reg <= cfg_data[pidmsc_pkg::PERIOD_W-1:0];
                    pidmsc_pkg::REG_DRIVE_MODE:
                        mode_reg <= cfg_data[pidmsc_pkg::MODE_W-1:0];
                    pidmsc_pkg::REG_START_POWER: power_reg    <= start_clamped;
                    default:                     ;
                endcase
            end
            else if (state_reg == pidmsc_pkg::ST_PWR)
            begin
                power_reg <= power_next;
            end

            if (state_reg == pidmsc_pkg::ST_LOAD)
            begin
                last_error_reg <= err_reg;
            end

            if (state_reg == pidmsc_pkg::ST_INTEG)
            begin
                integral_reg <= integ_next;
            end

            // output register occupancy
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working and output payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            err_reg <= err_in;
            ivl_reg <= interval;
        end
        if (mul_start)
        begin
            op_neg_reg <= mul_neg;
        end
        if (post_load)
        begin
            sv_reg <= sv_w;
        end
        if (state_reg == pidmsc_pkg::ST_I_START)
        begin
            term_p_reg <= sv_sat;
        end
        if (state_reg == pidmsc_pkg::ST_D_START)
        begin
            term_i_reg <= sv_sat;
        end
        if (state_reg == pidmsc_pkg::ST_SUM)
        begin
            corr_reg <= corr_next;
        end
        if (out_load)
        begin
            pwm_compare_reg <= q_w[pidmsc_pkg::PERIOD_W-1:0];
            bridge_one_reg  <= (mode_reg == pidmsc_pkg::MODE_FORWARD) ||
                               (mode_reg == pidmsc_pkg::MODE_BRAKE);
            bridge_two_reg  <= (mode_reg == pidmsc_pkg::MODE_REVERSE) ||
                               (mode_reg == pidmsc_pkg::MODE_BRAKE);
            drive_power_reg <= power_reg[pidmsc_pkg::START_W-1:0];
            correction_reg  <= corr_reg;
        end
    end

    // Shared bit-serial multiplier
    pidmsc_serial_mul #(
        .A_W (IW),
        .B_W (M_W)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .busy    (mul_busy),
        .product (mul_product)
    );

    // Derivative divider
    pidmsc_serial_div #(
        .NUM_W (DIV_W)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .num_mag (div_num),
        .num_neg (diff[M_W]),
        .den     (ivl_reg),
        .status  (div_status)
    );

    assign out_valid     = out_valid_reg;
    assign pwm_compare   = pwm_compare_reg;
    assign bridge_in_one = bridge_one_reg;
    assign bridge_in_two = bridge_two_reg;
    assign drive_power   = drive_power_reg;
    assign correction    = correction_reg;

endmodule
